// File: hdl/l4cs_pkg.sv
// shared types and constants of the ipv4 l4 checksum engine
package l4cs_pkg;

  // default depth of the queue between parser and checksum finisher
  localparam int L4CS_QUEUE_DEPTH = 4;

  // protocol numbers and checksum field offsets inside the segment
  localparam logic [7:0] L4_TCP_PROTOCOL  = 8'd6;
  localparam logic [7:0] L4_UDP_PROTOCOL  = 8'd17;
  localparam logic [4:0] TCP_FIELD_OFFSET = 5'd16;
  localparam logic [4:0] UDP_FIELD_OFFSET = 5'd6;

  // header byte positions and limits
  localparam logic [15:0] IDX_VERSION   = 16'd0;
  localparam logic [15:0] IDX_LEN_HI    = 16'd2;
  localparam logic [15:0] IDX_LEN_LO    = 16'd3;
  localparam logic [15:0] IDX_PROTOCOL  = 16'd9;
  localparam logic [15:0] IDX_ADDR_LO   = 16'd12;
  localparam logic [15:0] IDX_ADDR_HI   = 16'd19;
  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
  localparam logic [3:0]  VERSION_IPV4  = 4'h4;
  localparam logic [3:0]  MIN_HDR_WORDS = 4'd5;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_IPV4  = 3'd1,
    ST_NO_PROTO  = 3'd2,
    ST_SEG_SHORT = 3'd3,
    ST_HDR_SHORT = 3'd4,
    ST_TRUNC     = 3'd5
  } status_t;

  // per-packet record handed from parser to finisher
  typedef struct packed {
    logic [31:0] sum;
    logic [7:0]  proto;
    logic [15:0] plen;
    logic [6:0]  pos;
    status_t     status;
  } pkt_rec_t;

endpackage

// File: hdl/l4cs_front.sv
// byte parser: captures header fields, accumulates the sum, classifies the packet
module l4cs_front import l4cs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       rec_push,
  output pkt_rec_t   rec
);

  logic [15:0] byte_count_r, byte_count_nxt;
  logic [3:0]  header_words_r, header_words_nxt;
  logic        version_bad_r, version_bad_nxt;
  logic [15:0] total_length_r, total_length_nxt;
  logic [7:0]  protocol_r, protocol_nxt;
  logic [4:0]  field_offset_r, field_offset_nxt;
  logic [31:0] sum_r, sum_nxt;

  // values as seen after this byte
  logic [3:0]  hw_eff;
  logic        vb_eff;
  logic [15:0] tl_eff;
  logic [7:0]  proto_eff;
  logic [4:0]  fo_eff;
  logic [31:0] sum_eff;
  logic [5:0]  hlen;
  logic [6:0]  pos_base;
  logic [6:0]  pos_next;
  logic [31:0] weighted;
  logic        addr_hit;
  logic        seg_hit;
  logic [16:0] received;
  logic [16:0] plen_ext;
  status_t     status;

  // header field capture
  always_comb begin
    hw_eff    = header_words_r;
    vb_eff    = version_bad_r;
    tl_eff    = total_length_r;
    proto_eff = protocol_r;
    fo_eff    = field_offset_r;
    unique case (byte_count_r)
      IDX_VERSION: begin
        vb_eff = (data_byte[7:4] != VERSION_IPV4);
        hw_eff = data_byte[3:0];
      end
      IDX_LEN_HI: tl_eff = {data_byte, total_length_r[7:0]};
      IDX_LEN_LO: tl_eff = {total_length_r[15:8], data_byte};
      IDX_PROTOCOL: begin
        proto_eff = data_byte;
        if (data_byte == L4_TCP_PROTOCOL) begin
          fo_eff = TCP_FIELD_OFFSET;
        end else if (data_byte == L4_UDP_PROTOCOL) begin
          fo_eff = UDP_FIELD_OFFSET;
        end else begin
          fo_eff = 5'd0;
        end
      end
      default: ;
    endcase
  end

  // sum accumulation: addresses plus segment, checksum field read as zero
  assign hlen     = {hw_eff, 2'b00};
  assign pos_base = {1'b0, hlen} + {2'b00, fo_eff};
  assign pos_next = pos_base + 7'd1;
  assign weighted = byte_count_r[0] ? {24'd0, data_byte} : {16'd0, data_byte, 8'd0};
  assign addr_hit = (byte_count_r >= IDX_ADDR_LO) && (byte_count_r <= IDX_ADDR_HI);
  assign seg_hit  = (byte_count_r >= {10'd0, hlen}) && (byte_count_r < tl_eff) &&
                    (byte_count_r != {9'd0, pos_base}) &&
                    (byte_count_r != {9'd0, pos_next});
  assign sum_eff  = sum_r + (addr_hit ? weighted : 32'd0) + (seg_hit ? weighted : 32'd0);

  // classification at the final byte
  assign received = {1'b0, byte_count_r} + 17'd1;
  assign plen_ext = {1'b0, tl_eff} - {11'd0, hlen};

  always_comb begin
    priority if (vb_eff) begin
      status = ST_NOT_IPV4;
    end else if (hw_eff < MIN_HDR_WORDS) begin
      status = ST_HDR_SHORT;
    end else if ((received < {1'b0, tl_eff}) || (received < {11'd0, hlen})) begin
      status = ST_TRUNC;
    end else if (fo_eff == 5'd0) begin
      status = ST_NO_PROTO;
    end else if ({1'b0, tl_eff} < ({10'd0, pos_base} + 17'd2)) begin
      status = ST_SEG_SHORT;
    end else begin
      status = ST_OK;
    end
  end

  // record for the finisher
  assign rec_push   = accept && last_byte;
  assign rec.sum    = sum_eff;
  assign rec.proto  = proto_eff;
  assign rec.plen   = plen_ext[15:0];
  assign rec.pos    = (status == ST_OK) ? pos_base : 7'd0;
  assign rec.status = status;

  // next state: advance on a byte, clear after the final one
  always_comb begin
    byte_count_nxt   = byte_count_r;
    header_words_nxt = header_words_r;
    version_bad_nxt  = version_bad_r;
    total_length_nxt = total_length_r;
    protocol_nxt     = protocol_r;
    field_offset_nxt = field_offset_r;
    sum_nxt          = sum_r;
    if (accept) begin
      if (last_byte) begin
        byte_count_nxt   = 16'd0;
        header_words_nxt = 4'd0;
        version_bad_nxt  = 1'b0;
        total_length_nxt = 16'd0;
        protocol_nxt     = 8'd0;
        field_offset_nxt = 5'd0;
        sum_nxt          = 32'd0;
      end else begin
        byte_count_nxt   = (byte_count_r != COUNT_MAX) ? byte_count_r + 16'd1 : byte_count_r;
        header_words_nxt = hw_eff;
        version_bad_nxt  = vb_eff;
        total_length_nxt = tl_eff;
        protocol_nxt     = proto_eff;
        field_offset_nxt = fo_eff;
        sum_nxt          = sum_eff;
      end
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r   <= 16'd0;
      header_words_r <= 4'd0;
      version_bad_r  <= 1'b0;
      total_length_r <= 16'd0;
      protocol_r     <= 8'd0;
      field_offset_r <= 5'd0;
      sum_r          <= 32'd0;
    end else begin
      byte_count_r   <= byte_count_nxt;
      header_words_r <= header_words_nxt;
      version_bad_r  <= version_bad_nxt;
      total_length_r <= total_length_nxt;
      protocol_r     <= protocol_nxt;
      field_offset_r <= field_offset_nxt;
      sum_r          <= sum_nxt;
    end
  end

endmodule

// File: hdl/l4cs_queue.sv
// short record queue between parser and finisher
module l4cs_queue import l4cs_pkg::*; #(
  parameter int DEPTH = L4CS_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  pkt_rec_t wr_rec,
  output logic     full,
  input  logic     rd_en,
  output logic     rd_valid,
  output pkt_rec_t rd_rec
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  pkt_rec_t         store_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign full     = (count_r == CNT_FULL);
  assign rd_valid = (count_r != '0);
  assign rd_rec   = store_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + CW'(1);
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // record storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_ptr_r] <= wr_rec;
    end
  end

endmodule

// File: hdl/l4cs_back.sv
// checksum finisher: pseudo-header add, carry folds, complement, result register
module l4cs_back import l4cs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        rec_valid,
  input  pkt_rec_t    rec,
  output logic        rec_pop,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] checksum,
  output logic [6:0]  checksum_position,
  output logic [2:0]  status
);

  logic        a_valid_r;
  logic [17:0] a_sum_r;
  logic        a_udp_r;
  logic [6:0]  a_pos_r;
  status_t     a_status_r;

  logic        o_valid_r;
  logic [15:0] o_csum_r;
  logic [6:0]  o_pos_r;
  status_t     o_status_r;

  logic        o_ready;
  logic        a_ready;
  logic [16:0] first_fold;
  logic [17:0] a_sum_nxt;
  logic [16:0] fold_a;
  logic [15:0] fold_b;
  logic [15:0] csum_raw;
  logic [15:0] csum_nxt;

  // flow control: each stage moves when the one after it has room
  assign o_ready = !o_valid_r || pop;
  assign a_ready = !a_valid_r || o_ready;
  assign rec_pop = rec_valid && a_ready;

  // stage a: fold the running sum once and add protocol and segment length
  assign first_fold = {1'b0, rec.sum[15:0]} + {1'b0, rec.sum[31:16]};
  assign a_sum_nxt  = {1'b0, first_fold} + {10'd0, rec.proto} + {2'd0, rec.plen};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      a_sum_r    <= a_sum_nxt;
      a_udp_r    <= (rec.proto == L4_UDP_PROTOCOL);
      a_pos_r    <= rec.pos;
      a_status_r <= rec.status;
    end
  end

  // stage b: carry folds, complement, udp zero sent as all ones, zero on failure
  assign fold_a   = {1'b0, a_sum_r[15:0]} + {15'd0, a_sum_r[17:16]};
  assign fold_b   = fold_a[15:0] + {15'd0, fold_a[16]};
  assign csum_raw = ~fold_b;

  always_comb begin
    priority if (a_status_r != ST_OK) begin
      csum_nxt = 16'd0;
    end else if (a_udp_r && (csum_raw == 16'd0)) begin
      csum_nxt = 16'hFFFF;
    end else begin
      csum_nxt = csum_raw;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (o_ready) begin
      o_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && a_valid_r) begin
      o_csum_r   <= csum_nxt;
      o_pos_r    <= a_pos_r;
      o_status_r <= a_status_r;
    end
  end

  assign empty             = !o_valid_r;
  assign checksum          = o_csum_r;
  assign checksum_position = o_pos_r;
  assign status            = o_status_r;

endmodule

// File: hdl/ipv4_l4_checksum_engine_core.sv
// top level of the ipv4 tcp/udp checksum engine
// Takes an IPv4 packet one byte per cycle on in_data_byte, with in_last_byte on the
// final byte, and returns one request per packet: the TCP or UDP checksum over the
// pseudo-header and segment, the byte position of the checksum field, and a status
// (0 ok, 1 not IPv4, 2 neither TCP nor UDP, 3 segment too short, 4 header length below
// 5, 5 truncated). A byte is taken every cycle while full is low; full rises only when
// the record queue between the byte parser and the checksum finisher holds QUEUE_DEPTH
// packets that the output side has not drained. A record passes the record queue,
// finisher stage a and the result register; without output stalls back-to-back
// one-byte packets yield one result per cycle, and the parser's 32-bit accumulate
// and the finisher's two-stage fold each handle one request per cycle.
module ipv4_l4_checksum_engine_core import l4cs_pkg::*; #(
  parameter int QUEUE_DEPTH = L4CS_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        push,
  output logic        full,
  output logic [15:0] out_checksum,
  output logic [6:0]  out_checksum_position,
  output logic [2:0]  out_status,
  output logic        empty,
  input  logic        pop
);

  logic     accept;
  logic     rec_push;
  pkt_rec_t rec_in;
  logic     rec_valid;
  logic     rec_pop;
  pkt_rec_t rec_out;

  assign accept = push && !full;

  // byte parser
  l4cs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .rec_push  (rec_push),
    .rec       (rec_in)
  );

  // record queue
  l4cs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (rec_push),
    .wr_rec   (rec_in),
    .full     (full),
    .rd_en    (rec_pop),
    .rd_valid (rec_valid),
    .rd_rec   (rec_out)
  );

  // checksum finisher
  l4cs_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .rec_valid         (rec_valid),
    .rec               (rec_out),
    .rec_pop           (rec_pop),
    .empty             (empty),
    .pop               (pop),
    .checksum          (out_checksum),
    .checksum_position (out_checksum_position),
    .status            (out_status)
  );

endmodule

// File: hdl/l4cs_checker.sv
// port-level checks of the checksum engine and their binding
module l4cs_checker import l4cs_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        full,
  input logic [15:0] out_checksum,
  input logic [6:0]  out_checksum_position,
  input logic [2:0]  out_status,
  input logic        empty,
  input logic        pop
);

  // the engine comes out of reset empty and not full
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not cleared by reset");

  // failed packets carry neither checksum nor position
  a_fail_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_status != ST_OK)) |->
      ((out_checksum == 16'd0) && (out_checksum_position == 7'd0)))
    else $error("failed request carries checksum or position");

  // a good packet places its checksum within a legal header plus offset
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_status == ST_OK)) |->
      ((out_checksum_position >= 7'd26) && (out_checksum_position <= 7'd76)))
    else $error("checksum position out of range");

  // a stalled request holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=>
      (!empty && $stable(out_checksum) && $stable(out_status) &&
       $stable(out_checksum_position)))
    else $error("stalled request changed");

endmodule

bind ipv4_l4_checksum_engine_core l4cs_checker u_l4cs_checker (.*);
